// ===== sv/ipv6at_pkg.sv =====
// ----------------------------------------------------------------------------
// IPv6 address table package
// Shared types, codes and a helper function for the address table.
// ----------------------------------------------------------------------------
package ipv6at_pkg;

    localparam int unsigned DEFAULT_TABLE_ENTRIES = 8;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_EXACT  = 2'd1,
        ACT_PREFIX = 2'd2,
        ACT_SELECT = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_ADDED       = 3'd0,
        ST_DUPLICATE   = 3'd1,
        ST_FULL        = 3'd2,
        ST_UNSPECIFIED = 3'd3,
        ST_FOUND       = 3'd4,
        ST_NOT_FOUND   = 3'd5,
        ST_SELECTED    = 3'd6,
        ST_NONE        = 3'd7
    } status_t;

    localparam logic [2:0] KIND_UNICAST   = 3'd0;
    localparam logic [2:0] KIND_ANYCAST   = 3'd2;
    localparam logic [2:0] KIND_SOLICITED = 3'd3;
    localparam logic [2:0] KIND_LINK      = 3'd4;
    localparam logic [2:0] KIND_GLOBAL    = 3'd5;

    localparam logic [15:0] LINK_LOCAL_TOP = 16'hfe80;
    localparam logic [15:0] MCAST_LINK_TOP = 16'hff02;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic        preferred;
        logic [2:0]  addr_kind;
    } request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  entries_added;
        logic [2:0]  entry_index;
        logic [63:0] result_high;
        logic [63:0] result_low;
        logic [7:0]  prefix_len;
    } result_t;

    // Classified request handed from the front part to the back part.
    typedef struct packed {
        request_t    req;
        logic        unspecified;
        logic        local_dest;
        logic        has_companion;
        logic [63:0] comp_low;
    } job_t;

    // Leading zero count of a 64-bit word (64 when all zero).
    function automatic logic [6:0] lead_zeros(input logic [63:0] x);
        logic [6:0] n;
        logic       found;
        n = 7'd64;
        found = 1'b0;
        for (int i = 63; i >= 0; i--) begin
            if (!found && x[i]) begin
                n = 7'(63 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// ===== sv/ipv6at_front.sv =====
// ----------------------------------------------------------------------------
// IPv6 address table front part
// Accepts requests, classifies them and places them in a small job queue.
// ----------------------------------------------------------------------------
module ipv6at_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  ipv6at_pkg::request_t req,
    output logic                 job_valid,
    input  logic                 job_take,
    output ipv6at_pkg::job_t     job
);
    import ipv6at_pkg::*;

    job_t       q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    job_t       cls;
    logic       do_push, do_pop;

    // Classify the incoming request.
    always_comb
    begin
        cls = '0;
        cls.req = req;
        cls.unspecified = (req.addr_high == 64'd0) && (req.addr_low == 64'd0);
        cls.local_dest = (req.addr_high[63:48] == LINK_LOCAL_TOP) ||
                         (req.addr_high[63:48] == MCAST_LINK_TOP);
        cls.has_companion = (req.addr_kind == KIND_UNICAST) ||
                            (req.addr_kind == KIND_ANYCAST) ||
                            (req.addr_kind == KIND_LINK) ||
                            (req.addr_kind == KIND_GLOBAL);
        cls.comp_low = {16'h0000, 16'h0001, 8'hff, req.addr_low[23:0]};
    end

    assign full      = cnt_reg == 2'd2;
    assign job_valid = cnt_reg != 2'd0;
    assign job       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = job_take && job_valid;

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)  rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("job queue count out of range");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |=> (cnt_reg <= 2'd1))
        else $error("job queue popped while empty");
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !job_take) |=> full)
        else $error("job queue lost an entry");

endmodule

// ===== sv/ipv6at_back.sv =====
// ----------------------------------------------------------------------------
// IPv6 address table back part
// Holds the table and walks it one entry per cycle to carry out each job.
// ----------------------------------------------------------------------------
module ipv6at_back #(
    parameter int unsigned TABLE_ENTRIES = ipv6at_pkg::DEFAULT_TABLE_ENTRIES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_take,
    input  ipv6at_pkg::job_t    job,
    output logic                empty,
    input  logic                pop,
    output ipv6at_pkg::result_t result
);
    import ipv6at_pkg::*;

    localparam int unsigned IW = $clog2(TABLE_ENTRIES);
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_WALK, S_COMP_WALK, S_FINISH, S_PLEN, S_OUT
    } state_t;

    logic [63:0] mem_high [TABLE_ENTRIES];
    logic [63:0] mem_low  [TABLE_ENTRIES];
    logic        mem_pref [TABLE_ENTRIES];

    state_t      state_reg;
    job_t        job_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic        hit_reg, comp_hit_reg, sel_reg;
    logic [IW-1:0] hit_idx_reg, sel_idx_reg;
    logic [7:0]  best_reg;
    logic [63:0] sel_high_reg, sel_low_reg;
    result_t     res_reg;

    logic [IW-1:0] ri;
    logic [63:0] e_high, e_low;
    logic        e_pref, e_link, e_exact, e_hit;
    logic [63:0] xh, xl;
    logic [6:0]  lzh, lzl;
    logic [7:0]  cp;
    logic [63:0] comp_high;
    logic        add_ok;
    result_t     fin_res;

    assign comp_high = {MCAST_LINK_TOP, 48'd0};
    assign ri      = idx_reg[IW-1:0];
    assign e_high  = mem_high[ri];
    assign e_low   = mem_low[ri];
    assign e_pref  = mem_pref[ri];
    assign e_link  = e_high[63:48] == LINK_LOCAL_TOP;

    // Compare of the walked entry with the job address.
    always_comb
    begin
        e_exact = (e_high == job_reg.req.addr_high) && (e_low == job_reg.req.addr_low);
        e_hit   = (e_high == job_reg.req.addr_high) &&
                  ((job_reg.req.action == ACT_PREFIX) || (e_low == job_reg.req.addr_low));
        xh  = (state_reg == S_PLEN ? sel_high_reg : e_high) ^ job_reg.req.addr_high;
        xl  = (state_reg == S_PLEN ? sel_low_reg : e_low) ^ job_reg.req.addr_low;
        lzh = lead_zeros(xh);
        lzl = lead_zeros(xl);
        cp  = (xh != 64'd0) ? {1'b0, lzh} : (8'd64 + {1'b0, lzl});
    end

    // An add that stores its address once the walk is done.
    assign add_ok = (job_reg.req.action == ACT_ADD) && !job_reg.unspecified && !hit_reg &&
                    (count_reg < CW'(TABLE_ENTRIES));

    // Result built at the end of the walk.
    always_comb
    begin
        fin_res = '0;
        case (job_reg.req.action)
            ACT_ADD:
            begin
                if (job_reg.unspecified)
                    fin_res.status = ST_UNSPECIFIED;
                else if (hit_reg)
                    fin_res.status = ST_DUPLICATE;
                else if (count_reg >= CW'(TABLE_ENTRIES))
                    fin_res.status = ST_FULL;
                else
                begin
                    fin_res.status = ST_ADDED;
                    fin_res.entries_added = 2'd1;
                end
            end
            ACT_EXACT, ACT_PREFIX:
            begin
                fin_res.status = hit_reg ? ST_FOUND : ST_NOT_FOUND;
                fin_res.entry_index = 3'(hit_idx_reg);
            end
            default:
            begin
                if (sel_reg)
                begin
                    fin_res.status = ST_SELECTED;
                    fin_res.entry_index = 3'(sel_idx_reg);
                    fin_res.result_high = sel_high_reg;
                    fin_res.result_low = sel_low_reg;
                end
                else
                    fin_res.status = ST_NONE;
            end
        endcase
    end

    assign job_take = (state_reg == S_IDLE) && job_valid;
    assign empty    = state_reg != S_OUT;
    assign result   = res_reg;

    // Table writes: the new entry and its companion.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FINISH && add_ok)
        begin
            mem_high[count_reg[IW-1:0]] <= job_reg.req.addr_high;
            mem_low[count_reg[IW-1:0]]  <= job_reg.req.addr_low;
            mem_pref[count_reg[IW-1:0]] <= job_reg.req.preferred;
        end
        else if (state_reg == S_COMP_WALK && idx_reg == count_reg && !comp_hit_reg &&
                 count_reg < CW'(TABLE_ENTRIES))
        begin
            mem_high[count_reg[IW-1:0]] <= comp_high;
            mem_low[count_reg[IW-1:0]]  <= job_reg.comp_low;
            mem_pref[count_reg[IW-1:0]] <= job_reg.req.preferred;
        end
    end

    // Sequencer: walk entries, then finish and build the result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_reg   <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
            comp_hit_reg <= 1'b0;
            sel_reg   <= 1'b0;
            hit_idx_reg <= '0;
            sel_idx_reg <= '0;
            best_reg  <= 8'd0;
            sel_high_reg <= 64'd0;
            sel_low_reg <= 64'd0;
            res_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg   <= job;
                        idx_reg   <= '0;
                        hit_reg   <= 1'b0;
                        sel_reg   <= 1'b0;
                        best_reg  <= 8'd0;
                        hit_idx_reg <= '0;
                        sel_idx_reg <= '0;
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    if (idx_reg >= count_reg)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        if (job_reg.req.action == ACT_SELECT)
                        begin
                            if (e_pref && job_reg.local_dest && e_link)
                            begin
                                sel_reg <= 1'b1;
                                sel_idx_reg <= ri;
                                sel_high_reg <= e_high;
                                sel_low_reg <= e_low;
                            end
                            else if (e_pref && !job_reg.local_dest && !e_link &&
                                     cp >= best_reg)
                            begin
                                sel_reg <= 1'b1;
                                best_reg <= cp;
                                sel_idx_reg <= ri;
                                sel_high_reg <= e_high;
                                sel_low_reg <= e_low;
                            end
                        end
                        else if (!hit_reg &&
                                 (job_reg.req.action == ACT_ADD ? e_exact : e_hit))
                        begin
                            hit_reg <= 1'b1;
                            hit_idx_reg <= ri;
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_FINISH:
                begin
                    res_reg <= fin_res;
                    if (add_ok)
                    begin
                        count_reg <= count_reg + 1'b1;
                        if (job_reg.has_companion)
                        begin
                            idx_reg <= '0;
                            comp_hit_reg <= 1'b0;
                            state_reg <= S_COMP_WALK;
                        end
                        else
                            state_reg <= S_OUT;
                    end
                    else if (job_reg.req.action == ACT_SELECT && sel_reg)
                        state_reg <= S_PLEN;
                    else
                        state_reg <= S_OUT;
                end
                S_COMP_WALK:
                begin
                    if (idx_reg >= count_reg)
                    begin
                        if (!comp_hit_reg && count_reg < CW'(TABLE_ENTRIES))
                        begin
                            count_reg <= count_reg + 1'b1;
                            res_reg.entries_added <= 2'd2;
                        end
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        if (e_high == comp_high && e_low == job_reg.comp_low)
                            comp_hit_reg <= 1'b1;
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_PLEN:
                begin
                    res_reg.prefix_len <= cp;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (pop) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_ENTRIES))
        else $error("entry count exceeds table size");
    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + 1'b1))
        else $error("entry count moved by more than one");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !pop) |=> (state_reg == S_OUT && $stable(res_reg)))
        else $error("result changed while waiting");

endmodule

// ===== sv/ipv6_interface_address_table.sv =====
// ----------------------------------------------------------------------------
// IPv6 interface address table
// Add, lookup and source address selection over a small address table.
// ----------------------------------------------------------------------------
// Channel  | Handshake     | Payload
// request  | push / full   | req (request_t)
// result   | pop / empty   | res (result_t)
//
// The back part walks the table one entry per cycle through a single read
// port; an add with a companion walks it a second time, and a selection that
// finds an entry adds a prefix-length step. Reset empties the table at once.
// A two-deep job queue lets requests arrive while the back part works; a held
// result stalls the back part and, once the queue is full, new requests too.
module ipv6_interface_address_table #(
    parameter int unsigned TABLE_ENTRIES = ipv6at_pkg::DEFAULT_TABLE_ENTRIES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  ipv6at_pkg::request_t req,
    output logic                 empty,
    input  logic                 pop,
    output ipv6at_pkg::result_t  res
);
    import ipv6at_pkg::*;

    logic job_valid, job_take;
    job_t job;

    ipv6at_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .req(req),
        .job_valid(job_valid), .job_take(job_take), .job(job)
    );

    ipv6at_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_take(job_take),
        .job(job), .empty(empty), .pop(pop), .result(res)
    );

endmodule

// ===== tb/ipv6_interface_address_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 address table checker
// Watches the request and result channels, keeps a shadow address table,
// predicts every result and compares it field by field with the block.
// ----------------------------------------------------------------------------
module ipv6_interface_address_table_checker
    import ipv6at_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  logic     full,
    input  request_t req,
    input  logic     empty,
    input  logic     pop,
    input  result_t  res,
    output int       error_count,
    output int       pending_count
);

    // Shadow copy of the table.
    logic [63:0] shadow_high [TABLE_ENTRIES];
    logic [63:0] shadow_low [TABLE_ENTRIES];
    logic        shadow_pref [TABLE_ENTRIES];
    int          shadow_count;

    result_t expected_results [$];

    // Common prefix length of two 128-bit addresses, stopping at the first
    // differing bit.
    function automatic int prefix_match(logic [127:0] a, logic [127:0] b);
        logic [127:0] x;
        int           n;
        x = a ^ b;
        n = 0;
        while (n < 128 && !x[127 - n])
            n++;
        return n;
    endfunction

    function automatic int find_entry(logic [63:0] h, logic [63:0] l);
        for (int i = 0; i < shadow_count; i++)
            if (shadow_high[i] == h && shadow_low[i] == l)
                return i;
        return -1;
    endfunction

    function automatic void store_shadow(logic [63:0] h, logic [63:0] l, logic p);
        shadow_high[shadow_count] = h;
        shadow_low[shadow_count] = l;
        shadow_pref[shadow_count] = p;
        shadow_count++;
    endfunction

    // Apply one request to the shadow table and return its expected result.
    function automatic result_t predict_table_result(request_t r);
        result_t     e;
        logic [63:0] comp_low;
        int          hit;
        int          best;
        int          m;
        logic        local_dest;
        e = '0;
        case (action_t'(r.action))
            ACT_ADD:
            begin
                if (r.addr_high == 0 && r.addr_low == 0)
                    e.status = ST_UNSPECIFIED;
                else if (find_entry(r.addr_high, r.addr_low) >= 0)
                    e.status = ST_DUPLICATE;
                else if (shadow_count >= TABLE_ENTRIES)
                    e.status = ST_FULL;
                else
                begin
                    store_shadow(r.addr_high, r.addr_low, r.preferred);
                    e.status = ST_ADDED;
                    e.entries_added = 2'd1;
                    if (r.addr_kind inside {KIND_UNICAST, KIND_ANYCAST, KIND_LINK,
                                            KIND_GLOBAL})
                    begin
                        comp_low = {32'h0000_0001, 8'hff, r.addr_low[23:0]};
                        if (find_entry({MCAST_LINK_TOP, 48'h0}, comp_low) < 0
                            && shadow_count < TABLE_ENTRIES)
                        begin
                            store_shadow({MCAST_LINK_TOP, 48'h0}, comp_low, r.preferred);
                            e.entries_added = 2'd2;
                        end
                    end
                end
            end
            ACT_EXACT, ACT_PREFIX:
            begin
                hit = -1;
                for (int i = 0; i < shadow_count && hit < 0; i++)
                    if (shadow_high[i] == r.addr_high &&
                        (r.action == ACT_PREFIX || shadow_low[i] == r.addr_low))
                        hit = i;
                if (hit >= 0)
                begin
                    e.status = ST_FOUND;
                    e.entry_index = 3'(hit);
                end
                else
                    e.status = ST_NOT_FOUND;
            end
            default:
            begin
                hit = -1;
                best = 0;
                local_dest = r.addr_high[63:48] == LINK_LOCAL_TOP ||
                             r.addr_high[63:48] == MCAST_LINK_TOP;
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (!shadow_pref[i])
                        continue;
                    if (local_dest)
                    begin
                        if (shadow_high[i][63:48] == LINK_LOCAL_TOP)
                            hit = i;
                    end
                    else if (shadow_high[i][63:48] != LINK_LOCAL_TOP)
                    begin
                        m = prefix_match({r.addr_high, r.addr_low},
                                         {shadow_high[i], shadow_low[i]});
                        if (m >= best)
                        begin
                            best = m;
                            hit = i;
                        end
                    end
                end
                if (hit >= 0)
                begin
                    e.status = ST_SELECTED;
                    e.entry_index = 3'(hit);
                    e.result_high = shadow_high[hit];
                    e.result_low = shadow_low[hit];
                    e.prefix_len = 8'(prefix_match({r.addr_high, r.addr_low},
                                                   {shadow_high[hit], shadow_low[hit]}));
                end
                else
                    e.status = ST_NONE;
            end
        endcase
        return e;
    endfunction

    // Predict on accepted requests, compare on accepted results.
    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
        begin
            shadow_count = 0;
            expected_results.delete();
            error_count <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("Result with no request outstanding: %h", res);
                    error_count <= error_count + 1;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (res !== e)
                    begin
                        if (res.status !== e.status)
                            $error("status expected %0d actual %0d", e.status, res.status);
                        if (res.entries_added !== e.entries_added)
                            $error("entries_added expected %0d actual %0d",
                                   e.entries_added, res.entries_added);
                        if (res.entry_index !== e.entry_index)
                            $error("entry_index expected %0d actual %0d",
                                   e.entry_index, res.entry_index);
                        if (res.result_high !== e.result_high)
                            $error("result_high expected %h actual %h",
                                   e.result_high, res.result_high);
                        if (res.result_low !== e.result_low)
                            $error("result_low expected %h actual %h",
                                   e.result_low, res.result_low);
                        if (res.prefix_len !== e.prefix_len)
                            $error("prefix_len expected %0d actual %0d",
                                   e.prefix_len, res.prefix_len);
                        error_count <= error_count + 1;
                    end
                end
            end
            if (push && !full)
                expected_results.push_back(predict_table_result(req));
        end
    end

    assign pending_count = expected_results.size();

endmodule

// ===== tb/ipv6_interface_address_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 address table testbench
// Drives directed and random table requests with random idling on both sides,
// including a long result stall and a full drain, and reports the verdict.
// ----------------------------------------------------------------------------
module ipv6_interface_address_table_tb;
    import ipv6at_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     push;
    logic     full;
    request_t req;
    logic     empty;
    logic     pop;
    result_t  res;
    int       error_count;
    int       pending_count;
    bit       quiet_phase;
    bit       hold_results;

    ipv6_interface_address_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .req   (req),
        .empty (empty),
        .pop   (pop),
        .res   (res)
    );

    ipv6_interface_address_table_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .req           (req),
        .empty         (empty),
        .pop           (pop),
        .res           (res),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    always #5 clk = ~clk;

    // Small pools of prefixes so lookups and selections hit often.
    logic [63:0] prefix_pool [6];
    logic [63:0] used_high [$];
    logic [63:0] used_low [$];

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random request with content biased toward the stored addresses.
    function automatic request_t random_request();
        request_t r;
        int       k;
        r.action = 2'($urandom_range(0, 3));
        r.preferred = 1'($urandom);
        r.addr_kind = 3'($urandom_range(0, 7));
        k = $urandom_range(0, 9);
        if (k < 4 && used_high.size() > 0)
        begin
            k = $urandom_range(0, used_high.size() - 1);
            r.addr_high = used_high[k];
            r.addr_low = used_low[k];
            if ($urandom_range(0, 2) == 0)
                r.addr_low[$urandom_range(0, 63)] ^= 1'b1;
        end
        else if (k < 8)
        begin
            r.addr_high = prefix_pool[$urandom_range(0, 5)];
            r.addr_low = $urandom_range(0, 3) == 0 ? rand64() : 64'($urandom_range(1, 40));
        end
        else if (k == 8)
        begin
            r.addr_high = 64'h0;
            r.addr_low = $urandom_range(0, 1) ? 64'h0 : rand64();
        end
        else
        begin
            r.addr_high = rand64();
            r.addr_low = rand64();
        end
        if (r.action == ACT_ADD)
        begin
            used_high.push_back(r.addr_high);
            used_low.push_back(r.addr_low);
        end
        return r;
    endfunction

    // Offer one request; full is checked at the falling edge, where it is stable,
    // so each request is taken once, at a rising edge.
    task automatic send_request(request_t r);
        int gap;
        if (!quiet_phase && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        req <= r;
        @(negedge clk);
        while (full)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    function automatic request_t make_request(action_t a, logic [63:0] h, logic [63:0] l,
                                              logic p, logic [2:0] kind);
        request_t r;
        r.action = a;
        r.addr_high = h;
        r.addr_low = l;
        r.preferred = p;
        r.addr_kind = kind;
        return r;
    endfunction

    // Result side: random pop bursts, a long hold when asked.
    initial
    begin
        int gap;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                pop <= 1'b0;
                repeat (200) @(posedge clk);
                hold_results = 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                pop <= 1'b0;
                gap = $urandom_range(1, 12);
                repeat (gap - 1) @(posedge clk);
            end
            else
                pop <= 1'b1;
        end
    end

    // Request side: a directed part, then random requests. The table is never
    // cleared, so it fills and lookups and selection carry on against it.
    initial
    begin
        logic [63:0] ll;
        clk = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        req = '0;
        quiet_phase = 1'b0;
        hold_results = 1'b0;
        ll = {LINK_LOCAL_TOP, 48'h0};
        prefix_pool[0] = 64'h2001_0db8_0000_0001;
        prefix_pool[1] = 64'h2001_0db8_0000_0002;
        prefix_pool[2] = ll;
        prefix_pool[3] = {MCAST_LINK_TOP, 48'h0};
        prefix_pool[4] = 64'hffff_ffff_ffff_ffff;
        prefix_pool[5] = 64'h2001_0db8_8000_0001;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, unspecified, companions, duplicates, full table.
        send_request(make_request(ACT_SELECT, 64'h2001_0db8_0000_0001, 64'h1, 1'b1, 3'd0));
        send_request(make_request(ACT_EXACT, 64'h0, 64'h0, 1'b0, 3'd0));
        send_request(make_request(ACT_ADD, 64'h0, 64'h0, 1'b1, KIND_UNICAST));
        send_request(make_request(ACT_ADD, ll, 64'h0211_22ff_fe33_4455, 1'b1, KIND_LINK));
        send_request(make_request(ACT_ADD, ll, 64'h0211_22ff_fe33_4455, 1'b1, KIND_LINK));
        send_request(make_request(ACT_ADD, 64'h2001_0db8_0000_0001, 64'h0000_0000_0033_4455,
                                  1'b1, KIND_GLOBAL));
        send_request(make_request(ACT_ADD, 64'h2001_0db8_0000_0001, 64'hffff_ffff_ffff_ffff,
                                  1'b0, KIND_ANYCAST));
        send_request(make_request(ACT_ADD, {MCAST_LINK_TOP, 48'h0}, 64'h1, 1'b1, 3'd1));
        send_request(make_request(ACT_ADD, 64'h2001_0db8_0000_0002, 64'h5, 1'b1, 3'd7));
        send_request(make_request(ACT_ADD, 64'hffff_ffff_ffff_ffff, 64'h1, 1'b1, 3'd6));
        send_request(make_request(ACT_ADD, 64'h2001_0db8_0000_0003, 64'h9, 1'b1, KIND_UNICAST));
        send_request(make_request(ACT_ADD, 64'h3000_0000_0000_0000, 64'h1, 1'b1, KIND_UNICAST));
        send_request(make_request(ACT_EXACT, ll, 64'h0211_22ff_fe33_4455, 1'b0, 3'd0));
        send_request(make_request(ACT_EXACT, ll, 64'h1, 1'b0, 3'd0));
        send_request(make_request(ACT_PREFIX, 64'h2001_0db8_0000_0001, 64'h0, 1'b0, 3'd0));
        send_request(make_request(ACT_PREFIX, 64'h1234, 64'h0, 1'b0, 3'd0));
        send_request(make_request(ACT_SELECT, ll, 64'h99, 1'b0, 3'd0));
        send_request(make_request(ACT_SELECT, {MCAST_LINK_TOP, 48'h0}, 64'h1, 1'b0, 3'd0));
        send_request(make_request(ACT_SELECT, 64'h2001_0db8_0000_0001, 64'h0000_0000_0033_4455,
                                  1'b0, 3'd0));
        send_request(make_request(ACT_SELECT, 64'hffff_ffff_ffff_ffff, 64'h1, 1'b0, 3'd0));
        send_request(make_request(ACT_SELECT, 64'h0, 64'h0, 1'b0, 3'd0));
        send_request(make_request(ACT_SELECT, 64'h7fff_ffff_ffff_ffff, 64'h0, 1'b0, 3'd0));

        // The sender pauses until every result has come.
        wait_drained();

        // Random requests against the full table; a long result hold part way.
        for (int n = 0; n < 1000; n++)
        begin
            if (n == 300)
                hold_results = 1'b1;
            if (n == 600)
                wait_drained();
            if (n == 850)
                quiet_phase = 1'b1;
            send_request(random_request());
        end
        push <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Overall time limit.
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
sv/ipv6at_pkg.sv
sv/ipv6at_front.sv
sv/ipv6at_back.sv
sv/ipv6_interface_address_table.sv
tb/ipv6_interface_address_table_checker.sv
tb/ipv6_interface_address_table_tb.sv
